/* hw/rtl/mes_pkg.sv */
// Shared widths, register codes and reduction helper for the exponent stream.
package mes_pkg;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned KEY_BITS_D = 16;
  localparam int unsigned MU_W       = 32;
  localparam int unsigned R_W        = 18;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned DIV_STEPS  = 32;

  localparam logic [0:0] REG_EXPONENT = 1'b0;
  localparam logic [0:0] REG_MODULUS  = 1'b1;

  typedef logic [VAL_W-1:0] val_t;

  // Bring a Barrett remainder below three times the modulus into range.
  function automatic val_t fold_mod(input logic [R_W-1:0] r, input val_t m);
    logic [R_W-1:0] t;
    logic [R_W-1:0] mm;
    begin
      mm = {{(R_W-VAL_W){1'b0}}, m};
      t  = r;
      if (t >= mm) t = t - mm;
      if (t >= mm) t = t - mm;
      if (t >= mm) t = t - mm;
      fold_mod = t[VAL_W-1:0];
    end
  endfunction
endpackage

/* hw/rtl/mes_if.sv */
// Stream channel interfaces for input and result beats.
interface mes_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value_in;
  logic        last_in;
  modport source (output valid, output value_in, output last_in, input ready);
  modport sink   (input valid, input value_in, input last_in, output ready);
endinterface

interface mes_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value_out;
  logic        last_out;
  modport source (output valid, output value_out, output last_out, input ready);
  modport sink   (input valid, input value_out, input last_out, output ready);
endinterface

/* hw/rtl/modular_exponent_stream.sv */
// Top level: pipelined modular exponentiation of a stream of 16-bit values.
// Usage:
//   in_s   - input beats (value_in, last_in), taken when valid and ready are high.
//   out_s  - result beats (value_out = value_in ** exponent mod modulus, last_out).
//   cfg_*  - APB-style port; exponent at byte 0x0, modulus at byte 0x4.
// Every beat runs through a fixed pipeline: three stages reduce the value by
// the modulus, then four stages per key bit (multiply, Barrett quotient,
// remainder, final fold) do one square and one conditional multiply.
// A new beat may enter every cycle unless the pipeline holds or the Barrett
// divider below is busy.
// A Barrett constant floor((2^32-1)/modulus) is built by a one-bit-per-cycle
// divider after reset and after each modulus write; while it runs,
// in_s.ready stays low. Configuration writes are always taken.
// Reset restores exponent 1 and modulus 1, empties the pipeline and starts
// the divider. When the receiver stalls with a result waiting, the whole
// pipeline holds; nothing is lost or repeated.
// A modulus of zero or one gives results of zero.
module modular_exponent_stream #(
  parameter int unsigned KEY_BITS = mes_pkg::KEY_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mes_in_if.sink                        in_s,
  mes_out_if.source                     out_s,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mes_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [mes_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [mes_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import mes_pkg::*;

  // Configuration registers
  val_t exp_r, mod_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= val_t'(1);
      mod_r <= val_t'(1);
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_EXPONENT: exp_r <= cfg_pwdata[VAL_W-1:0];
        REG_MODULUS:  mod_r <= cfg_pwdata[VAL_W-1:0];
        default:      exp_r <= exp_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_EXPONENT: cfg_prdata = {{(PDATA_W-VAL_W){1'b0}}, exp_r};
      REG_MODULUS:  cfg_prdata = {{(PDATA_W-VAL_W){1'b0}}, mod_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Barrett constant: restoring divide of all-ones by the modulus
  logic            div_busy_r;
  logic [4:0]      div_cnt_r;
  logic [VAL_W-1:0] rem_r;
  logic [MU_W-1:0] mu_r;
  logic [VAL_W:0]  rem_sh;
  logic            rem_ge;

  assign rem_sh = {rem_r, 1'b1};
  assign rem_ge = rem_sh >= {1'b0, mod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
      rem_r      <= '0;
    end else if (wr_en && cfg_paddr[2] == REG_MODULUS) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
      rem_r      <= '0;
    end else if (div_busy_r) begin
      rem_r     <= rem_ge ? VAL_W'(rem_sh - {1'b0, mod_r}) : rem_sh[VAL_W-1:0];
      div_cnt_r <= div_cnt_r + 5'd1;
      if (div_cnt_r == 5'(DIV_STEPS-1)) div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_busy_r) mu_r <= {mu_r[MU_W-2:0], rem_ge};
  end

  // Pipeline control: hold everything while a result waits
  logic adv;
  logic mod_small;
  assign adv       = !out_s.valid || out_s.ready;
  assign in_s.ready = adv && !div_busy_r;
  assign mod_small = mod_r <= val_t'(1);

  // Initial reduction of the input value
  logic             i1_v_r, i2_v_r;
  logic             i1_l_r, i2_l_r;
  val_t             i1_x_r, i2_m_r;
  val_t             i1_q_r;
  logic [R_W-1:0]   i2_r_r;
  logic [2*MU_W-1:0] i1_prod;

  assign i1_prod = {{MU_W{1'b0}}, {(MU_W-VAL_W){1'b0}}, in_s.value_in} * {{MU_W{1'b0}}, mu_r};

  logic             vld_r  [KEY_BITS+1];
  logic             lst_r  [KEY_BITS+1];
  val_t             acc_r  [KEY_BITS+1];
  val_t             base_r [KEY_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i1_v_r   <= 1'b0;
      i2_v_r   <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      i1_v_r   <= in_s.valid && in_s.ready;
      i2_v_r   <= i1_v_r;
      vld_r[0] <= i2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i1_x_r    <= in_s.value_in;
      i1_l_r    <= in_s.last_in;
      i1_q_r    <= i1_prod[MU_W+VAL_W-1:MU_W];
      i2_r_r    <= R_W'(i1_x_r)
                   - R_W'({{VAL_W{1'b0}}, i1_q_r} * {{VAL_W{1'b0}}, mod_r});
      i2_l_r    <= i1_l_r;
      i2_m_r    <= mod_r;
      base_r[0] <= fold_mod(i2_r_r, i2_m_r);
      acc_r[0]  <= val_t'(1);
      lst_r[0]  <= i2_l_r;
    end
  end

  // One square and one conditional multiply per key bit
  for (genvar b = 0; b < KEY_BITS; b++) begin : g_bit
    logic           ebit;
    logic           va_r, vb_r, vc_r;
    logic           la_r, lb_r, lc_r;
    logic [2*VAL_W-1:0] pa_r, ps_r, pa2_r, ps2_r;
    val_t           qa_r, qs_r;
    logic [R_W-1:0] ra_r, rs_r;
    logic [2*MU_W-1:0] qa_prod, qs_prod;

    if (b < VAL_W) begin : g_eb
      assign ebit = exp_r[b];
    end else begin : g_ez
      assign ebit = 1'b0;
    end

    assign qa_prod = {{MU_W{1'b0}}, pa_r} * {{MU_W{1'b0}}, mu_r};
    assign qs_prod = {{MU_W{1'b0}}, ps_r} * {{MU_W{1'b0}}, mu_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r       <= 1'b0;
        vb_r       <= 1'b0;
        vc_r       <= 1'b0;
        vld_r[b+1] <= 1'b0;
      end else if (adv) begin
        va_r       <= vld_r[b];
        vb_r       <= va_r;
        vc_r       <= vb_r;
        vld_r[b+1] <= vc_r;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r  <= ebit ? acc_r[b] * base_r[b] : {{VAL_W{1'b0}}, acc_r[b]};
        ps_r  <= base_r[b] * base_r[b];
        la_r  <= lst_r[b];
        qa_r  <= qa_prod[MU_W+VAL_W-1:MU_W];
        qs_r  <= qs_prod[MU_W+VAL_W-1:MU_W];
        pa2_r <= pa_r;
        ps2_r <= ps_r;
        lb_r  <= la_r;
        ra_r  <= pa2_r[R_W-1:0] - R_W'({{VAL_W{1'b0}}, qa_r} * {{VAL_W{1'b0}}, mod_r});
        rs_r  <= ps2_r[R_W-1:0] - R_W'({{VAL_W{1'b0}}, qs_r} * {{VAL_W{1'b0}}, mod_r});
        lc_r  <= lb_r;
        acc_r[b+1]  <= fold_mod(ra_r, mod_r);
        base_r[b+1] <= fold_mod(rs_r, mod_r);
        lst_r[b+1]  <= lc_r;
      end
    end
  end

  assign out_s.valid     = vld_r[KEY_BITS];
  assign out_s.value_out = mod_small ? '0 : acc_r[KEY_BITS];
  assign out_s.last_out  = lst_r[KEY_BITS];

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> !in_s.ready)
    else $error("input taken while Barrett constant is being built");
  a_small_mod_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && mod_small) |-> out_s.value_out == '0)
    else $error("modulus of one or zero gave a nonzero result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && !out_s.ready) |=>
      (out_s.valid && $stable(out_s.value_out) && $stable(out_s.last_out)))
    else $error("result beat changed while the receiver stalled");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(div_busy_r) |-> $past(div_cnt_r) == 5'(DIV_STEPS-1))
    else $error("divider ended early");
`endif
endmodule

/* tb/sv/modular_exponent_stream_checker.sv */
`timescale 1ns / 1ps
// Result checker: predicts each result beat from the accepted input beats and compares.
module modular_exponent_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  mes_in_if           in_m,
  mes_out_if          out_m,
  input  logic [15:0] exponent_q,
  input  logic [15:0] modulus_q,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } power_beat_t;

  power_beat_t expected_powers[$];

  // Right-to-left square and multiply, products kept at full width.
  function automatic logic [15:0] power_mod(input logic [15:0] base_in,
                                            input logic [15:0] expo,
                                            input logic [15:0] modulus);
    logic [31:0] acc;
    logic [31:0] base;
    begin
      if (modulus <= 16'd1) return 16'd0;
      acc  = 32'd1;
      base = {16'd0, base_in} % {16'd0, modulus};
      for (int b = 0; b < 16; b++) begin
        if (expo[b]) acc = (acc * base) % {16'd0, modulus};
        base = (base * base) % {16'd0, modulus};
      end
      return acc[15:0];
    end
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    fail_count++;
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    power_beat_t exp_beat;
    if (rst_n) begin
      if (in_m.valid && in_m.ready) begin
        exp_beat.value = power_mod(in_m.value_in, exponent_q, modulus_q);
        exp_beat.last  = in_m.last_in;
        expected_powers.push_back(exp_beat);
      end
      if (out_m.valid && out_m.ready) begin
        result_count++;
        if (expected_powers.size() == 0) begin
          report("unexpected beat", out_m.value_out, 16'd0);
        end else begin
          exp_beat = expected_powers.pop_front();
          if (out_m.value_out !== exp_beat.value)
            report("value_out", out_m.value_out, exp_beat.value);
          if (out_m.last_out !== exp_beat.last)
            report("last_out", {15'd0, out_m.last_out}, {15'd0, exp_beat.last});
        end
      end
    end
    pending_count = expected_powers.size();
  end
endmodule

/* tb/sv/modular_exponent_stream_tb.sv */
`timescale 1ns / 1ps
// Testbench top: drives input beats, register writes and receiver stalls, then gives the verdict.
module modular_exponent_stream_tb;
  import mes_pkg::*;

  localparam int RANDOM_BEATS = 1150;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr = '0;
  logic [PDATA_W-1:0]  cfg_pwdata = '0;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;

  // Shadow of the registers; follows each completed write.
  logic [15:0] exponent_q = 16'd1;
  logic [15:0] modulus_q  = 16'd1;

  int fail_count, pending_count, result_count;
  int beats_sent = 0;
  int settings_used = 0;

  mes_in_if  in_ch();
  mes_out_if out_ch();

  modular_exponent_stream i_dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_s(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  modular_exponent_stream_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_m(in_ch), .out_m(out_ch),
    .exponent_q(exponent_q), .modulus_q(modulus_q),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    begin
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
    end
  endfunction

  // Receiver: stall in bursts, with stall-free stretches now and then.
  int stall_left = 0;
  int calm_left = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(100, 400);
      else stall_left = gap_len();
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value_in = '0;
    in_ch.last_in = 1'b0;
  end

  // Hold one beat until the handshake completes, then drop valid during any gap that follows.
  task automatic send_beat(input logic [15:0] value, input logic last);
    int idle;
    begin
      in_ch.valid    <= 1'b1;
      in_ch.value_in <= value;
      in_ch.last_in  <= last;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      beats_sent++;
      @(negedge clk);
      idle = gap_len();
      if (idle > 0) begin
        in_ch.valid <= 1'b0;
        repeat (idle) @(negedge clk);
      end
    end
  endtask

  // Wait for every expected beat, then a further DRAIN_CYCLES, so nothing is in flight.
  task automatic drain();
    begin
      in_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
  endtask

  // Setup cycle, then access cycle; the register takes the data at the access edge.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [15:0] data);
    begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= addr;
      cfg_pwdata  <= {16'($urandom_range(0, 65535)), data};
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      if (addr == PADDR_W'(4 * REG_EXPONENT)) exponent_q <= data;
      else modulus_q <= data;
      @(negedge clk);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
    end
  endtask

  task automatic set_key(input logic [15:0] expo, input logic [15:0] modulus);
    begin
      write_reg(PADDR_W'(4 * REG_EXPONENT), expo);
      write_reg(PADDR_W'(4 * REG_MODULUS), modulus);
      settings_used++;
    end
  endtask

  task automatic random_beats(input int count);
    logic [15:0] v;
    begin
      for (int k = 0; k < count; k++) begin
        case ($urandom_range(0, 5))
          0: v = 16'h0000;
          1: v = 16'hFFFF;
          2: v = modulus_q + 16'($urandom_range(0, 2)) - 16'd1;
          default: v = 16'($urandom_range(0, 65535));
        endcase
        send_beat(v, ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    logic [15:0] mods[5];
    logic [15:0] exps[5];
    mods = '{16'd3233, 16'd65535, 16'd2, 16'd1, 16'd0};
    exps = '{16'd17, 16'd65535, 16'd0, 16'd1, 16'd2753};

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset key: modulus one, every result zero.
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h1234, 1'b1);
    drain();

    // Directed: value extremes and special keys.
    for (int k = 0; k < 5; k++) begin
      set_key(exps[k], mods[k]);
      send_beat(16'h0000, 1'b0);
      send_beat(16'hFFFF, 1'b1);
      send_beat(16'h5A5A, 1'b0);
      send_beat(16'hA5A5, 1'b1);
      drain();
    end
    // Modulus largest with exponent zero.
    set_key(16'd0, 16'hFFFF);
    send_beat(16'h0001, 1'b1);
    send_beat(16'hFFFE, 1'b0);
    drain();

    // Random phases under varied keys; the sender waits for a full drain each time.
    for (int p = 0; p < 23; p++) begin
      set_key(16'($urandom_range(0, 65535)),
              ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 3))
                                          : 16'($urandom_range(2, 65535)));
      random_beats(RANDOM_BEATS / 23);
      drain();
    end

    $display("covered %0d input beats, %0d results, %0d key settings",
             beats_sent, result_count, settings_used);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
